/* rtl/jbt_pkg.sv */
// package for the json byte tokenizer: result record, token and error codes,
// character constants and the keyword spelling table; no dependencies
package jbt_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 16;

    // result kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_TOKEN = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // token types
    localparam logic [3:0] TT_LBRACE   = 4'd0;
    localparam logic [3:0] TT_RBRACE   = 4'd1;
    localparam logic [3:0] TT_LBRACKET = 4'd2;
    localparam logic [3:0] TT_RBRACKET = 4'd3;
    localparam logic [3:0] TT_COLON    = 4'd4;
    localparam logic [3:0] TT_COMMA    = 4'd5;
    localparam logic [3:0] TT_STRING   = 4'd6;
    localparam logic [3:0] TT_NUMBER   = 4'd7;
    localparam logic [3:0] TT_TRUE     = 4'd8;
    localparam logic [3:0] TT_FALSE    = 4'd9;
    localparam logic [3:0] TT_NULL     = 4'd10;
    localparam logic [3:0] TT_END      = 4'd11;

    // error codes
    localparam logic [1:0] ERR_UNEXPECTED   = 2'd0;
    localparam logic [1:0] ERR_UNTERMINATED = 2'd1;
    localparam logic [1:0] ERR_KEYWORD      = 2'd2;

    // characters
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;

    localparam int RES_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  token_type;
        logic [7:0]  value_char;
        logic [15:0] start_row;
        logic [15:0] start_column;
        logic [1:0]  error_code;
        logic        last_of_run;
    } jbt_result_t;

    function automatic jbt_result_t make_result(
        input logic [1:0]  kind,
        input logic [3:0]  token_type,
        input logic [7:0]  value_char,
        input logic [15:0] line,
        input logic [15:0] column,
        input logic [1:0]  error_code
    );
        jbt_result_t r;
        r.kind         = kind;
        r.token_type   = token_type;
        r.value_char   = value_char;
        r.start_row    = line;
        r.start_column = column;
        r.error_code   = error_code;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    // keyword spelling: 0 true, 1 false, 2 null
    function automatic logic [7:0] kw_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (idx)
            2'd0: begin
                case (pos)
                    3'd0: c = 8'h74; 3'd1: c = 8'h72; 3'd2: c = 8'h75; 3'd3: c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            2'd1: begin
                case (pos)
                    3'd0: c = 8'h66; 3'd1: c = 8'h61; 3'd2: c = 8'h6C; 3'd3: c = 8'h73;
                    3'd4: c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            2'd2: begin
                case (pos)
                    3'd0: c = 8'h6E; 3'd1: c = 8'h75; 3'd2: c = 8'h6C; 3'd3: c = 8'h6C;
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] idx);
        return (idx == 2'd1) ? 3'd5 : 3'd4;
    endfunction

    // candidates still alive after one more letter
    function automatic logic [2:0] kw_keep(
        input logic [2:0] cand,
        input logic [2:0] len,
        input logic [7:0] c
    );
        logic [2:0] keep;
        for (int i = 0; i < 3; i++) begin
            keep[i] = cand[i] && (len < kw_len(2'(i))) && (kw_char(2'(i), len) == c);
        end
        return keep;
    endfunction

endpackage

/* rtl/jbt_lexer.sv */
// lexer state and per-byte decision logic of the json byte tokenizer;
// yields up to two results per byte. depends on jbt_pkg
module jbt_lexer #(
    parameter int LINE_BITS   = jbt_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = jbt_pkg::COLUMN_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic [7:0]          in_byte,
    input  logic                in_end,
    output jbt_pkg::jbt_result_t res0,
    output jbt_pkg::jbt_result_t res1,
    output logic [1:0]          res_count
);
    import jbt_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STRING,
        MODE_ESCAPE,
        MODE_NUMBER,
        MODE_KEYWORD,
        MODE_ERROR
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [LINE_BITS-1:0]   line_reg, line_next, tok_line_reg, tok_line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next, tok_col_reg, tok_col_next;
    logic [2:0]             cand_reg, cand_next;
    logic [2:0]             len_reg, len_next;

    // idle-mode handling of the current byte
    logic        idle_emit;
    jbt_result_t idle_res;
    mode_t       idle_mode;
    logic        idle_tok;
    logic [15:0] line16, col16, tok_line16, tok_col16;

    logic        e0, e1, use_idle;
    jbt_result_t r0, r1;
    logic        kw_hit;
    logic [3:0]  kw_type;
    logic [7:0]  esc_char;
    logic        is_digit, is_lower;

    always_comb begin
        line16     = 16'(line_reg);
        col16      = 16'(col_reg);
        tok_line16 = 16'(tok_line_reg);
        tok_col16  = 16'(tok_col_reg);
        is_digit   = in_byte inside {[8'h30:8'h39]};
        is_lower   = in_byte inside {[8'h61:8'h7A]};

        idle_emit = 1'b0;
        idle_res  = make_result(KIND_TOKEN, TT_LBRACE, 8'h00, line16, col16, ERR_UNEXPECTED);
        idle_mode = MODE_IDLE;
        idle_tok  = 1'b0;
        case (in_byte)
            CH_SPACE, CH_TAB, CH_LF, CH_CR: idle_emit = 1'b0;
            CH_LBRACE: idle_emit = 1'b1;
            CH_RBRACE: begin
                idle_emit = 1'b1;
                idle_res.token_type = TT_RBRACE;
            end
            CH_LBRACKET: begin
                idle_emit = 1'b1;
                idle_res.token_type = TT_LBRACKET;
            end
            CH_RBRACKET: begin
                idle_emit = 1'b1;
                idle_res.token_type = TT_RBRACKET;
            end
            CH_COLON: begin
                idle_emit = 1'b1;
                idle_res.token_type = TT_COLON;
            end
            CH_COMMA: begin
                idle_emit = 1'b1;
                idle_res.token_type = TT_COMMA;
            end
            default: begin
                if (in_byte == CH_QUOTE) begin
                    idle_tok  = 1'b1;
                    idle_mode = MODE_STRING;
                end else if (in_byte == CH_MINUS || is_digit) begin
                    idle_tok  = 1'b1;
                    idle_mode = MODE_NUMBER;
                    idle_emit = 1'b1;
                    idle_res  = make_result(KIND_CHAR, TT_NUMBER, in_byte, line16, col16,
                                            ERR_UNEXPECTED);
                end else if (is_lower) begin
                    idle_tok  = 1'b1;
                    idle_mode = MODE_KEYWORD;
                end else begin
                    idle_emit = 1'b1;
                    idle_mode = MODE_ERROR;
                    idle_res  = make_result(KIND_ERROR, TT_LBRACE, 8'h00, line16, col16,
                                            ERR_UNEXPECTED);
                end
            end
        endcase
    end

    always_comb begin
        kw_hit  = 1'b0;
        kw_type = TT_TRUE;
        for (int i = 2; i >= 0; i--) begin
            if (cand_reg[i] && len_reg == kw_len(2'(i))) begin
                kw_hit  = 1'b1;
                kw_type = TT_TRUE + 4'(i);
            end
        end
        case (in_byte)
            CH_LOWER_N: esc_char = CH_LF;
            CH_LOWER_T: esc_char = CH_TAB;
            CH_LOWER_R: esc_char = CH_CR;
            default:    esc_char = in_byte;
        endcase
    end

    always_comb begin
        e0        = 1'b0;
        e1        = 1'b0;
        use_idle  = 1'b0;
        r0        = make_result(KIND_TOKEN, TT_END, 8'h00, line16, col16, ERR_UNEXPECTED);
        r1        = r0;
        mode_next     = mode_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        cand_next     = cand_reg;
        len_next      = len_reg;
        line_next     = line_reg;
        col_next      = col_reg;

        if (in_end) begin
            case (mode_reg)
                MODE_IDLE: e0 = 1'b1;
                MODE_NUMBER: begin
                    e0 = 1'b1;
                    e1 = 1'b1;
                    r0 = make_result(KIND_TOKEN, TT_NUMBER, 8'h00, tok_line16, tok_col16,
                                     ERR_UNEXPECTED);
                end
                MODE_KEYWORD: begin
                    e0 = 1'b1;
                    if (kw_hit) begin
                        e1 = 1'b1;
                        r0 = make_result(KIND_TOKEN, kw_type, 8'h00, tok_line16, tok_col16,
                                         ERR_UNEXPECTED);
                    end else begin
                        r0 = make_result(KIND_ERROR, TT_LBRACE, 8'h00, tok_line16,
                                         tok_col16, ERR_KEYWORD);
                    end
                end
                MODE_STRING, MODE_ESCAPE: begin
                    e0 = 1'b1;
                    r0 = make_result(KIND_ERROR, TT_LBRACE, 8'h00, tok_line16, tok_col16,
                                     ERR_UNTERMINATED);
                end
                default: e0 = 1'b0;
            endcase
            // end of document restarts everything
            mode_next     = MODE_IDLE;
            line_next     = LINE_BITS'(1);
            col_next      = COLUMN_BITS'(1);
            tok_line_next = LINE_BITS'(1);
            tok_col_next  = COLUMN_BITS'(1);
            cand_next     = 3'b111;
            len_next      = 3'd0;
        end else begin
            case (mode_reg)
                MODE_IDLE: use_idle = 1'b1;
                MODE_STRING: begin
                    e0 = 1'b1;
                    if (in_byte == CH_QUOTE) begin
                        r0 = make_result(KIND_TOKEN, TT_STRING, 8'h00, tok_line16, tok_col16,
                                         ERR_UNEXPECTED);
                        mode_next = MODE_IDLE;
                    end else if (in_byte == CH_BACKSLASH) begin
                        e0 = 1'b0;
                        mode_next = MODE_ESCAPE;
                    end else begin
                        r0 = make_result(KIND_CHAR, TT_STRING, in_byte, tok_line16, tok_col16,
                                         ERR_UNEXPECTED);
                    end
                end
                MODE_ESCAPE: begin
                    e0 = 1'b1;
                    r0 = make_result(KIND_CHAR, TT_STRING, esc_char, tok_line16, tok_col16,
                                     ERR_UNEXPECTED);
                    mode_next = MODE_STRING;
                end
                MODE_NUMBER: begin
                    e0 = 1'b1;
                    if (is_digit) begin
                        r0 = make_result(KIND_CHAR, TT_NUMBER, in_byte, tok_line16, tok_col16,
                                         ERR_UNEXPECTED);
                    end else begin
                        r0 = make_result(KIND_TOKEN, TT_NUMBER, 8'h00, tok_line16, tok_col16,
                                         ERR_UNEXPECTED);
                        use_idle = 1'b1;
                    end
                end
                MODE_KEYWORD: begin
                    if (is_lower) begin
                        cand_next = kw_keep(cand_reg, len_reg, in_byte);
                        len_next  = (len_reg != 3'd7) ? len_reg + 3'd1 : len_reg;
                    end else if (kw_hit) begin
                        e0 = 1'b1;
                        r0 = make_result(KIND_TOKEN, kw_type, 8'h00, tok_line16, tok_col16,
                                         ERR_UNEXPECTED);
                        use_idle = 1'b1;
                    end else begin
                        e0 = 1'b1;
                        r0 = make_result(KIND_ERROR, TT_LBRACE, 8'h00, tok_line16,
                                         tok_col16, ERR_KEYWORD);
                        mode_next = MODE_ERROR;
                    end
                end
                default: e0 = 1'b0;
            endcase

            if (use_idle) begin
                e1        = idle_emit;
                r1        = idle_res;
                mode_next = idle_mode;
                if (idle_tok) begin
                    tok_line_next = line_reg;
                    tok_col_next  = col_reg;
                end
                if (idle_mode == MODE_KEYWORD) begin
                    cand_next = kw_keep(3'b111, 3'd0, in_byte);
                    len_next  = 3'd1;
                end
            end

            // position counters saturate
            if (in_byte == CH_LF) begin
                if (line_reg != '1) line_next = line_reg + LINE_BITS'(1);
                col_next = COLUMN_BITS'(1);
            end else if (col_reg != '1) begin
                col_next = col_reg + COLUMN_BITS'(1);
            end
        end

        res0      = e0 ? r0 : r1;
        res1      = r1;
        res_count = {1'b0, e0} + {1'b0, e1};
        res0.last_of_run = (res_count == 2'd1);
        res1.last_of_run = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            line_reg     <= LINE_BITS'(1);
            col_reg      <= COLUMN_BITS'(1);
            tok_line_reg <= LINE_BITS'(1);
            tok_col_reg  <= COLUMN_BITS'(1);
            cand_reg     <= 3'b111;
            len_reg      <= 3'd0;
        end else if (fire) begin
            mode_reg     <= mode_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            cand_reg     <= cand_next;
            len_reg      <= len_next;
        end
    end

endmodule

/* rtl/jbt_res_fifo.sv */
// four-entry result queue of the json byte tokenizer: takes up to two results
// per cycle, gives one per transaction. depends on jbt_pkg
module jbt_res_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           wr_count,
    input  jbt_pkg::jbt_result_t wr_data0,
    input  jbt_pkg::jbt_result_t wr_data1,
    output logic                 space_ok,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output jbt_pkg::jbt_result_t rd_data
);
    import jbt_pkg::*;

    localparam int PTR_BITS = $clog2(RES_DEPTH);

    jbt_result_t           entry_reg [RES_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_BITS:0]     count_reg, count_next;
    logic                  pop;

    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;
    // room for a full pair regardless of the read side
    assign space_ok = (count_reg <= (PTR_BITS+1)'(RES_DEPTH - 2));

    always_comb begin
        count_next = count_reg + (PTR_BITS+1)'(wr_count) - (PTR_BITS+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (wr_count != 2'd0) entry_reg[wr_ptr_reg] <= wr_data0;
        if (wr_count == 2'd2) entry_reg[wr_ptr_reg + PTR_BITS'(1)] <= wr_data1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(wr_count);
            if (pop) rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/json_byte_tokenizer_top.sv */
// top level of the json byte tokenizer: input register, lexer and result queue
// depends on jbt_pkg, jbt_lexer and jbt_res_fifo
//
// Streaming JSON lexer. Feed one text byte per transaction on the s_ side
// (s_tuser high marks end of document, byte ignored); tokens, decoded string
// bytes, raw number bytes and errors come out on the m_ side, m_tlast marking
// the last result caused by one input transaction. The block takes one byte
// per clock cycle while the result queue has room for a pair: the lexer writes
// the zero, one or two results of each byte into a four-entry result queue, so
// a byte that yields two results (a number or keyword ended by a byte that
// yields a result itself, or the end mark after a number or complete keyword)
// takes two transfers on the m_ side. The first result of a byte is offered
// on the m_ side after the input register and the result queue. After an error
// nothing is emitted until the end mark, which restarts line and column at 1.
module json_byte_tokenizer_top #(
    parameter int LINE_BITS   = jbt_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = jbt_pkg::COLUMN_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // token_type, value_char, start_row, start_column,
                                   // error_code, zero pad
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast    // last_of_run
);
    import jbt_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;
    logic        fire, space_ok;
    logic [1:0]  res_count;
    jbt_result_t res0, res1, head;

    assign fire     = in_valid_reg && space_ok;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tuser;
        end
    end

    jbt_lexer #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_lexer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .in_byte   (in_byte_reg),
        .in_end    (in_end_reg),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    jbt_res_fifo u_res_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_count (fire ? res_count : 2'd0),
        .wr_data0 (res0),
        .wr_data1 (res1),
        .space_ok (space_ok),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (head)
    );

    assign m_tdata = {2'b00, head.error_code, head.start_column, head.start_row,
                      head.value_char, head.token_type};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;

endmodule
